// ===== rtl/core/bsbd_pkg.sv =====
// Shared types and constants for the byte stack with bottom drain.
// Used by every module under rtl/core except bsbd_ram; depends on nothing.
package bsbd_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int MAX_TAKE_DEF = 64;

  localparam int DATA_W = 8;
  localparam int CNT_W  = 7;
  localparam int CAP_W  = 9;
  localparam int FILL_W = 9;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // register index, taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_TAKE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_TAKE_ERR = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HOLD,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;    // input beat taken this cycle
    logic out_imm;   // load output from the immediate result
    logic save_imm;  // park the immediate result in the pending register
    logic out_pend;  // load output from the pending register
    logic out_rd;    // load output from memory read data
    logic rd_next;   // issue the next read of a take
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic empty;
    logic take_bad;
    logic take_zero;
    logic last_rd;
  } sts_t;

endpackage

// ===== rtl/core/bsbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module bsbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/bsbd_cfg.sv =====
// APB register block: holds the capacity register.
// Depends on bsbd_pkg.
module bsbd_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsbd_pkg::APB_AW-1:0]  paddr,
  input  logic [bsbd_pkg::APB_DW-1:0]  pwdata,
  output logic [bsbd_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  output logic [bsbd_pkg::CAP_W-1:0]   capacity
);
  import bsbd_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (wr_en && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DW'(capacity);
    end
  end

endmodule

// ===== rtl/core/bsbd_ctrl.sv =====
// Controller FSM: input handshake and sequencing of result beats.
// Depends on bsbd_pkg; drives bsbd_dp through cmd_t, reads sts_t.
module bsbd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  bsbd_pkg::kind_t kind,
  input  bsbd_pkg::sts_t  sts,
  output bsbd_pkg::cmd_t  cmd
);
  import bsbd_pkg::*;

  state_t state, state_next;
  logic   imm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pop of a held byte and a nonzero legal take go through memory
  assign imm = !((kind == KIND_POP && !sts.empty) ||
                 (kind == KIND_TAKE && !sts.take_bad && !sts.take_zero));

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (imm) begin
            if (sts.out_free) begin
              cmd.out_imm = 1'b1;
            end else begin
              cmd.save_imm = 1'b1;
              state_next   = ST_HOLD;
            end
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.out_pend = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_rd = 1'b1;
          if (sts.last_rd) begin
            state_next = ST_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bsbd_dp.sv =====
// Datapath: circular byte store, level and base pointers, output register.
// Depends on bsbd_pkg and bsbd_ram; controlled by bsbd_ctrl.
module bsbd_dp #(
  parameter int DEPTH    = bsbd_pkg::DEPTH_DEF,
  parameter int MAX_TAKE = bsbd_pkg::MAX_TAKE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bsbd_pkg::cmd_t               cmd,
  output bsbd_pkg::sts_t               sts,
  input  bsbd_pkg::kind_t              kind,
  input  logic [bsbd_pkg::DATA_W-1:0]  data_in,
  input  logic [bsbd_pkg::CNT_W-1:0]   take_count,
  input  logic [bsbd_pkg::CAP_W-1:0]   capacity,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [bsbd_pkg::DATA_W-1:0]  out_data,
  output logic                         out_dvalid,
  output bsbd_pkg::status_t            out_status,
  output logic [bsbd_pkg::FILL_W-1:0]  out_fill,
  output logic                         out_last
);
  import bsbd_pkg::*;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = LVL_W + 1;
  localparam int WIDE_W = (LVL_W > CAP_W) ? LVL_W : CAP_W;
  localparam int TAKE_W = $clog2(MAX_TAKE + 1);

  logic [LVL_W-1:0]  level;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] rd_ptr;
  logic [TAKE_W-1:0] remain;
  status_t           pend_status;
  logic [FILL_W-1:0] pend_fill;

  logic [WIDE_W-1:0] level_w, cnt_w, cap_w, eff_cap;
  logic              full, empty, take_bad, take_zero;
  logic              do_push, do_pop, do_clear, do_take;
  logic              re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] rdata;
  status_t           imm_status;
  logic [FILL_W-1:0] imm_fill;

  // base + offset modulo DEPTH; both operands stay below DEPTH + 1
  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                  input logic [LVL_W-1:0]  off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(a) + SUM_W'(off);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return ADDR_W'(sum);
  endfunction

  assign level_w = WIDE_W'(level);
  assign cnt_w   = WIDE_W'(take_count);
  assign cap_w   = WIDE_W'(capacity);

  always_comb begin
    eff_cap = cap_w;
    if (cap_w < WIDE_W'(2)) begin
      eff_cap = WIDE_W'(2);
    end else if (cap_w > WIDE_W'(DEPTH)) begin
      eff_cap = WIDE_W'(DEPTH);
    end
  end

  assign full      = level_w >= eff_cap;
  assign empty     = (level == '0);
  assign take_bad  = (take_count > CNT_W'(MAX_TAKE)) || (cnt_w > level_w);
  assign take_zero = (take_count == '0);

  assign do_push  = cmd.accept && kind == KIND_PUSH && !full;
  assign do_pop   = cmd.accept && kind == KIND_POP && !empty;
  assign do_clear = cmd.accept && kind == KIND_CLEAR;
  assign do_take  = cmd.accept && kind == KIND_TAKE && !take_bad && !take_zero;

  // memory: push writes above the top, pop reads the top, take walks up from base
  assign waddr = wrap_add(base, level);
  assign re    = do_pop || do_take || cmd.rd_next;

  always_comb begin
    if (do_pop) begin
      raddr = wrap_add(base, level - LVL_W'(1));
    end else if (do_take) begin
      raddr = base;
    end else begin
      raddr = rd_ptr;
    end
  end

  bsbd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (waddr),
    .wdata (data_in),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // single-beat result for everything that needs no memory read
  always_comb begin
    imm_status = STAT_OK;
    imm_fill   = FILL_W'(level);
    case (kind)
      KIND_PUSH: begin
        if (full) begin
          imm_status = STAT_OVERFLOW;
        end else begin
          imm_fill = FILL_W'(level + LVL_W'(1));
        end
      end
      KIND_POP: begin
        imm_status = STAT_EMPTY;
      end
      KIND_CLEAR: begin
        imm_fill = '0;
      end
      KIND_TAKE: begin
        if (take_bad) begin
          imm_status = STAT_TAKE_ERR;
        end
      end
      default: begin
        imm_status = STAT_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      base   <= '0;
      remain <= '0;
    end else begin
      if (do_push) begin
        level <= level + LVL_W'(1);
      end else if (do_pop) begin
        level <= level - LVL_W'(1);
      end else if (do_clear) begin
        level <= '0;
      end else if (do_take) begin
        level <= level - LVL_W'(take_count);
        base  <= wrap_add(base, LVL_W'(take_count));
      end

      if (do_pop) begin
        remain <= TAKE_W'(1);
      end else if (do_take) begin
        remain <= TAKE_W'(take_count);
      end else if (cmd.out_rd) begin
        remain <= remain - TAKE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_take) begin
      rd_ptr <= wrap_add(base, LVL_W'(1));
    end else if (cmd.rd_next) begin
      rd_ptr <= wrap_add(rd_ptr, LVL_W'(1));
    end
    if (cmd.save_imm) begin
      pend_status <= imm_status;
      pend_fill   <= imm_fill;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_imm || cmd.out_pend || cmd.out_rd) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_imm) begin
      out_data   <= '0;
      out_dvalid <= 1'b0;
      out_status <= imm_status;
      out_fill   <= imm_fill;
      out_last   <= 1'b1;
    end else if (cmd.out_pend) begin
      out_data   <= '0;
      out_dvalid <= 1'b0;
      out_status <= pend_status;
      out_fill   <= pend_fill;
      out_last   <= 1'b1;
    end else if (cmd.out_rd) begin
      out_data   <= rdata;
      out_dvalid <= 1'b1;
      out_status <= STAT_OK;
      out_fill   <= FILL_W'(level);
      out_last   <= (remain == TAKE_W'(1));
    end
  end

  always_comb begin
    sts.out_free  = !out_valid || out_ready;
    sts.empty     = empty;
    sts.take_bad  = take_bad;
    sts.take_zero = take_zero;
    sts.last_rd   = (remain == TAKE_W'(1));
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(DEPTH))
    else $error("level above store depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(cmd.out_imm || cmd.out_pend || cmd.out_rd))
    else $error("output register loaded while stalled");

  a_rd_next_remain: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_next |-> remain > TAKE_W'(1))
    else $error("take read issued past its count");

  a_take_level: assert property (@(posedge clk) disable iff (rst)
    do_take |=> level == $past(level - LVL_W'(take_count)))
    else $error("take did not lower level by its count");

endmodule

// ===== rtl/core/byte_stack_with_bottom_drain.sv =====
// Byte stack with bottom drain: push, pop newest, clear, take oldest N bytes.
// Push, clear, zero-count takes and faults give one beat straight to the output
// register, or park it while that stalls; pop and take read the byte store's
// registered port first. Push/clear/faults take one item per cycle unless
// stalled; pop and take accept no beat until their last byte is loaded. Reset:
// sync, active high; level and base clear, capacity to 256, store not swept.
module byte_stack_with_bottom_drain #(
  parameter int DEPTH    = bsbd_pkg::DEPTH_DEF,
  parameter int MAX_TAKE = bsbd_pkg::MAX_TAKE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input beats
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // [7:0] data_in, [14:8] take_count
  input  logic [1:0]                   s_tuser,   // [1:0] kind
  // result beats
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,   // [7:0] data_out, [16:8] fill_level
  output logic [2:0]                   m_tuser,   // [0] data_valid, [2:1] status
  output logic                         m_tlast,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsbd_pkg::APB_AW-1:0]  paddr,
  input  logic [bsbd_pkg::APB_DW-1:0]  pwdata,
  output logic [bsbd_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import bsbd_pkg::*;

  cmd_t              cmd;
  sts_t              sts;
  kind_t             kind;
  logic [CAP_W-1:0]  capacity;
  logic [DATA_W-1:0] out_data;
  logic              out_dvalid;
  status_t           out_status;
  logic [FILL_W-1:0] out_fill;

  // unpack the input beat
  assign kind = kind_t'(s_tuser[1:0]);

  bsbd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // the controller only sequences; all storage and arithmetic sit in the datapath
  bsbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .kind     (kind),
    .sts      (sts),
    .cmd      (cmd)
  );

  // the store is a ring: a take advances its base instead of moving bytes down
  bsbd_dp #(
    .DEPTH    (DEPTH),
    .MAX_TAKE (MAX_TAKE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .data_in    (s_tdata[7:0]),
    .take_count (s_tdata[14:8]),
    .capacity   (capacity),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_data   (out_data),
    .out_dvalid (out_dvalid),
    .out_status (out_status),
    .out_fill   (out_fill),
    .out_last   (m_tlast)
  );

  // pack the result beat, zero fill to whole bytes
  assign m_tdata = {7'b0, out_fill, out_data};
  assign m_tuser = {out_status, out_dvalid};

endmodule
